// File: rtl/core/tlsd_pkg.sv
package tlsd_pkg;

  // Opcodes of an input beat
  localparam logic [1:0] OP_APPEND_FIRST  = 2'd0;
  localparam logic [1:0] OP_APPEND_SECOND = 2'd1;
  localparam logic [1:0] OP_RUN           = 2'd2;

  // Step counter of the sequencer
  localparam int STEP_W = 3;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t ST_IDLE    = 3'd0;  // take appends, wait for a run
  localparam step_t ST_OUTER   = 3'd1;  // start next outer element
  localparam step_t ST_LATCH   = 3'd2;  // capture outer element as probe
  localparam step_t ST_INNER   = 3'd3;  // test end of inner list
  localparam step_t ST_CMP     = 3'd4;  // compare probe with inner element
  localparam step_t ST_EMIT    = 3'd5;  // queue probe if unmatched
  localparam step_t ST_PASSEND = 3'd6;  // switch lists or finish
  localparam step_t ST_FINISH  = 3'd7;  // flush last result, clear lists

  // Jump conditions
  typedef enum logic [2:0] {
    C_ALWAYS     = 3'b000,
    C_NOT_RUN    = 3'b001,
    C_OUTER_DONE = 3'b010,
    C_INNER_DONE = 3'b011,
    C_NO_MATCH   = 3'b100,
    C_PASS0      = 3'b101
  } cond_t;

  // One control word
  typedef struct packed {
    logic  accept;       // input channel ready
    logic  start_elem;   // clear inner index and match flag
    logic  latch_probe;  // capture outer element
    logic  cmp;          // compare and advance inner index
    logic  emit;         // queue unmatched probe, advance outer index
    logic  pass_flip;    // move on to the second list
    logic  finish;       // deliver final result and clear lists
    cond_t cond;
    step_t target;
  } uword_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic run_beat;
    logic outer_done;
    logic inner_done;
    logic match;
    logic pass1;
    logic hold;
  } status_t;

  // Control store
  function automatic uword_t ucode_rom(step_t s);
    uword_t w;
    w = '0;
    w.cond = C_ALWAYS;
    w.target = ST_IDLE;
    unique case (s)
      ST_IDLE: begin
        w.accept = 1'b1;
        w.cond   = C_NOT_RUN;
        w.target = ST_IDLE;
      end
      ST_OUTER: begin
        w.start_elem = 1'b1;
        w.cond       = C_OUTER_DONE;
        w.target     = ST_PASSEND;
      end
      ST_LATCH: begin
        w.latch_probe = 1'b1;
        w.cond        = C_ALWAYS;
        w.target      = ST_INNER;
      end
      ST_INNER: begin
        w.cond   = C_INNER_DONE;
        w.target = ST_EMIT;
      end
      ST_CMP: begin
        w.cmp    = 1'b1;
        w.cond   = C_NO_MATCH;
        w.target = ST_INNER;
      end
      ST_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = C_ALWAYS;
        w.target = ST_OUTER;
      end
      ST_PASSEND: begin
        w.pass_flip = 1'b1;
        w.cond      = C_PASS0;
        w.target    = ST_OUTER;
      end
      ST_FINISH: begin
        w.finish = 1'b1;
        w.cond   = C_ALWAYS;
        w.target = ST_IDLE;
      end
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

// File: rtl/core/tlsd_in_if.sv
interface tlsd_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic signed [31:0] value;

  modport source (output valid, opcode, value, input ready);
  modport sink   (input valid, opcode, value, output ready);
endinterface

// File: rtl/core/tlsd_out_if.sv
interface tlsd_out_if;
  logic               valid;
  logic               ready;
  logic               from_second;
  logic signed [31:0] element;
  logic               none_found;
  logic               dropped;
  logic               last;

  modport source (output valid, from_second, element, none_found, dropped, last,
                  input ready);
  modport sink   (input valid, from_second, element, none_found, dropped, last,
                  output ready);
endinterface

// File: rtl/core/tlsd_seq.sv
module tlsd_seq
  import tlsd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  status_t status,
  output uword_t  uword
);

  step_t step;
  logic  take;

  // Fetch control word
  assign uword = ucode_rom(step);

  // Evaluate jump condition
  always_comb begin
    unique case (uword.cond)
      C_ALWAYS:     take = 1'b1;
      C_NOT_RUN:    take = !status.run_beat;
      C_OUTER_DONE: take = status.outer_done;
      C_INNER_DONE: take = status.inner_done;
      C_NO_MATCH:   take = !status.match;
      C_PASS0:      take = !status.pass1;
      default:      take = 1'b0;
    endcase
  end

  // Advance step counter, hold while a new result is blocked at the output
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_IDLE;
    end else if (!status.hold) begin
      step <= take ? uword.target : step + 1'b1;
    end
  end

endmodule

// File: rtl/core/tlsd_dp.sv
module tlsd_dp
  import tlsd_pkg::*;
#(
  parameter int LIST_DEPTH = 16
)
(
  input  logic       clk,
  input  logic       rst,
  input  uword_t     uword,
  output status_t    status,
  tlsd_in_if.sink    items,
  tlsd_out_if.source results
);

  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LIST_DEPTH);

  logic signed [31:0] first_mem [LIST_DEPTH];
  logic signed [31:0] second_mem [LIST_DEPTH];
  logic signed [31:0] first_q, second_q, probe;
  logic [CNT_W-1:0]   first_count, second_count, i_cnt, j_cnt;
  logic [CNT_W-1:0]   outer_count, inner_count;
  logic [IDX_W-1:0]   first_addr, second_addr;
  logic signed [31:0] outer_q, inner_q;
  logic               overflow, pass, found;
  logic               beat, first_wr, second_wr, blocked, cand_push, hold, load_out;
  logic               pend_valid, pend_side;
  logic signed [31:0] pend_elem;
  logic               out_valid, out_from_second, out_none_found, out_dropped, out_last;
  logic signed [31:0] out_element;

  // Input beat decode
  assign items.ready = uword.accept;
  assign beat        = items.valid && uword.accept;
  assign first_wr    = beat && (items.opcode == OP_APPEND_FIRST) && (first_count != DEPTH_C);
  assign second_wr   = beat && (items.opcode == OP_APPEND_SECOND) &&
                       (second_count != DEPTH_C);

  // Outer list is the first in pass 0 and the second in pass 1
  assign first_addr  = pass ? j_cnt[IDX_W-1:0] : i_cnt[IDX_W-1:0];
  assign second_addr = pass ? i_cnt[IDX_W-1:0] : j_cnt[IDX_W-1:0];
  assign outer_count = pass ? second_count : first_count;
  assign inner_count = pass ? first_count : second_count;
  assign outer_q     = pass ? second_q : first_q;
  assign inner_q     = pass ? first_q : second_q;

  // List memories, one write and one registered read each
  always_ff @(posedge clk) begin
    if (first_wr) begin
      first_mem[first_count[IDX_W-1:0]] <= items.value;
    end
    first_q <= first_mem[first_addr];
  end

  always_ff @(posedge clk) begin
    if (second_wr) begin
      second_mem[second_count[IDX_W-1:0]] <= items.value;
    end
    second_q <= second_mem[second_addr];
  end

  // Output stall and result queueing
  assign blocked   = out_valid && !results.ready;
  assign cand_push = uword.emit && !found;
  assign hold      = blocked && ((cand_push && pend_valid) || uword.finish);
  assign load_out  = !hold && ((cand_push && pend_valid) || uword.finish);

  always_comb begin
    status.run_beat   = beat && (items.opcode == OP_RUN);
    status.outer_done = (i_cnt == outer_count);
    status.inner_done = (j_cnt == inner_count);
    status.match      = (inner_q == probe);
    status.pass1      = pass;
    status.hold       = hold;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      first_count  <= '0;
      second_count <= '0;
      overflow     <= 1'b0;
      pass         <= 1'b0;
      i_cnt        <= '0;
      j_cnt        <= '0;
      found        <= 1'b0;
      pend_valid   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      // Append, flag drops on a full list
      if (first_wr) begin
        first_count <= first_count + 1'b1;
      end
      if (second_wr) begin
        second_count <= second_count + 1'b1;
      end
      if (beat && ((items.opcode == OP_APPEND_FIRST && first_count == DEPTH_C) ||
                   (items.opcode == OP_APPEND_SECOND && second_count == DEPTH_C))) begin
        overflow <= 1'b1;
      end
      // Walk the inner list
      if (uword.start_elem) begin
        j_cnt <= '0;
        found <= 1'b0;
      end
      if (uword.cmp) begin
        j_cnt <= j_cnt + 1'b1;
        if (status.match) begin
          found <= 1'b1;
        end
      end
      // Advance the outer list
      if (uword.emit && !hold) begin
        i_cnt <= i_cnt + 1'b1;
        if (cand_push) begin
          pend_valid <= 1'b1;
        end
      end
      if (uword.pass_flip && !pass) begin
        pass  <= 1'b1;
        i_cnt <= '0;
      end
      // Close the run
      if (uword.finish && !hold) begin
        first_count  <= '0;
        second_count <= '0;
        overflow     <= 1'b0;
        pass         <= 1'b0;
        i_cnt        <= '0;
        pend_valid   <= 1'b0;
      end
      // Output register valid
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (uword.latch_probe) begin
      probe <= outer_q;
    end
    if (cand_push && !hold) begin
      pend_side <= pass;
      pend_elem <= probe;
    end
    if (load_out) begin
      out_from_second <= pend_valid ? pend_side : 1'b0;
      out_element     <= pend_valid ? pend_elem : '0;
      out_none_found  <= uword.finish && !pend_valid;
      out_last        <= uword.finish;
      out_dropped     <= overflow;
    end
  end

  assign results.valid       = out_valid;
  assign results.from_second = out_from_second;
  assign results.element     = out_element;
  assign results.none_found  = out_none_found;
  assign results.dropped     = out_dropped;
  assign results.last        = out_last;

endmodule

// File: rtl/core/two_list_set_difference_unit.sv
// Channel   Dir  Payload                                          Accepted when
// items     in   opcode[1:0], value[31:0]                          valid && ready
// results   out  from_second, element[31:0], none_found,           valid && ready
//                dropped, last
//
// Appends are accepted back to back while idle.
// A run with n1 and n2 stored elements compares each element of either list
// with the elements of the other, its pace set by the single read port of each
// list memory. Input ready stays low from the run beat until its last result
// is loaded into the output register.
// Reset (rst, synchronous) empties both lists and clears the drop flag.
// A stalled output holds the sequencer only when a new result must be loaded.
module two_list_set_difference_unit
  import tlsd_pkg::*;
#(
  parameter int LIST_DEPTH = 16
)
(
  input  logic       clk,
  input  logic       rst,
  tlsd_in_if.sink    items,
  tlsd_out_if.source results
);

  uword_t  uword;
  status_t status;

  tlsd_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .uword  (uword)
  );

  tlsd_dp #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .uword   (uword),
    .status  (status),
    .items   (items),
    .results (results)
  );

endmodule

// File: rtl/core/tlsd_checker.sv
module tlsd_checker
  import tlsd_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        items_valid,
  input logic        items_ready,
  input logic [1:0]  items_opcode,
  input logic        results_valid,
  input logic        results_ready,
  input logic        results_from_second,
  input logic [31:0] results_element,
  input logic        results_none_found,
  input logic        results_last
);

  // Hold a stalled result beat
  assert property (@(posedge clk) disable iff (rst)
    results_valid && !results_ready |=> results_valid)
    else $error("result beat dropped while stalled");

  // Empty-run beat is the final beat, from the first list, with a zero element
  assert property (@(posedge clk) disable iff (rst)
    results_valid && results_none_found |->
      results_last && !results_from_second && (results_element == 32'd0))
    else $error("empty-run beat malformed");

  // Stop taking input after a run beat
  assert property (@(posedge clk) disable iff (rst)
    items_valid && items_ready && (items_opcode == OP_RUN) |=> !items_ready)
    else $error("input taken during a run");

  // A taken second-list result that is not last is not directly followed by a first-list beat
  assert property (@(posedge clk) disable iff (rst)
    results_valid && results_ready && results_from_second && !results_last |=>
      !results_valid || results_from_second)
    else $error("pass order broken");

endmodule

bind two_list_set_difference_unit tlsd_checker u_tlsd_checker (
  .clk                 (clk),
  .rst                 (rst),
  .items_valid         (items.valid),
  .items_ready         (items.ready),
  .items_opcode        (items.opcode),
  .results_valid       (results.valid),
  .results_ready       (results.ready),
  .results_from_second (results.from_second),
  .results_element     (results.element),
  .results_none_found  (results.none_found),
  .results_last        (results.last)
);
